// ----- rtl/upd_pkg.sv -----
// Shared types and character constants for the URL percent decoder.
package upd_pkg;

	typedef enum logic {
		JOB_SINGLE = 1'b0,
		JOB_QUAD   = 1'b1
	} job_kind_t;

	// One unit of work for the back end: a single byte or a four-byte raw escape.
	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] ch_a;
		logic [7:0] ch_b;
	} job_t;

	typedef struct packed {
		logic idle;
	} fe_status_t;

	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SP    = 8'h20;
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_BTICK = 8'h60;
	localparam logic [7:0] CHAR_APOS  = 8'h27;

	localparam logic [1:0] IDX_FIRST = 2'd0;
	localparam logic [1:0] IDX_C1    = 2'd1;
	localparam logic [1:0] IDX_C2    = 2'd2;
	localparam logic [1:0] IDX_LAST  = 2'd3;

endpackage

// ----- rtl/upd_front.sv -----
// Front end: takes input words, tracks escape state and classifies into jobs.
module upd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         in_char,
	input  logic               text_end,
	input  logic               q_full,
	output logic               push,
	output upd_pkg::job_t      push_job,
	output upd_pkg::fe_status_t status
);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_FIRST  = 3'b010,
		PH_SECOND = 3'b100
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] first_q, first_d;
	logic       accept;
	logic       emit;

	typedef struct packed {
		logic       hit;
		logic [7:0] value;
	} pair_t;

	function automatic logic pass_char(input logic [7:0] c);
		logic alpha, digit;
		alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
		digit = (c >= 8'h30 && c <= 8'h39);
		return alpha || digit || c == 8'h20 || c == 8'h0A || c == 8'h26 ||
			c == 8'h2E || c == 8'h3D || c == 8'h5F;
	endfunction

	function automatic pair_t lookup_pair(input logic [7:0] c1, input logic [7:0] c2);
		pair_t      r;
		logic       lo_ok;
		logic [3:0] lo;
		logic       ok;
		lo_ok = 1'b1;
		lo    = 4'd0;
		if (c2 >= 8'h30 && c2 <= 8'h39) begin
			lo = c2[3:0];
		end else if ((c2 >= 8'h41 && c2 <= 8'h46) || (c2 >= 8'h61 && c2 <= 8'h66)) begin
			lo = c2[3:0] + 4'd9;
		end else begin
			lo_ok = 1'b0;
		end
		unique case (c1)
			8'h32:   ok = (lo >= 4'd1);
			8'h33:   ok = (lo >= 4'd10);
			8'h34:   ok = (c2 == 8'h30);
			8'h35:   ok = (lo >= 4'd11);
			8'h36:   ok = (c2 == 8'h30);
			8'h37:   ok = (lo >= 4'd11) && (lo <= 4'd14);
			default: ok = 1'b0;
		endcase
		r.hit   = lo_ok && ok;
		r.value = {c1[3:0], lo};
		return r;
	endfunction

	pair_t pair;

	assign in_stall    = q_full;
	assign accept      = in_valid && !q_full;
	assign push        = accept && emit;
	assign status.idle = (phase_q == PH_IDLE);
	assign pair        = lookup_pair(first_q, in_char);

	always_comb begin
		phase_d        = phase_q;
		first_d        = first_q;
		emit           = 1'b0;
		push_job.kind  = upd_pkg::JOB_SINGLE;
		push_job.ch_a  = in_char;
		push_job.ch_b  = in_char;
		unique case (phase_q)
			PH_FIRST: begin
				phase_d = PH_SECOND;
				first_d = in_char;
			end
			PH_SECOND: begin
				phase_d = PH_IDLE;
				first_d = 8'h00;
				if (first_q == 8'h30 && (in_char == 8'h44 || in_char == 8'h64)) begin
					emit          = 1'b1;
					push_job.ch_a = upd_pkg::CHAR_NL;
				end else if (first_q == 8'h30 && (in_char == 8'h41 || in_char == 8'h61)) begin
					emit = 1'b0;
				end else if (pair.hit) begin
					emit          = 1'b1;
					push_job.ch_a = pair.value;
				end else begin
					emit          = 1'b1;
					push_job.kind = upd_pkg::JOB_QUAD;
					push_job.ch_a = first_q;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (pass_char(in_char)) begin
					emit = 1'b1;
				end else if (in_char == upd_pkg::CHAR_PLUS) begin
					emit          = 1'b1;
					push_job.ch_a = upd_pkg::CHAR_SP;
				end else if (in_char == upd_pkg::CHAR_PCT) begin
					phase_d = PH_FIRST;
				end
			end
		endcase
		if (text_end) begin
			phase_d = PH_IDLE;
			first_d = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			first_q <= 8'h00;
		end else if (accept) begin
			phase_q <= phase_d;
			first_q <= first_d;
		end
	end

endmodule

// ----- rtl/upd_queue.sv -----
// Short job queue between front and back end.
module upd_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  upd_pkg::job_t push_job,
	input  logic          pop,
	output upd_pkg::job_t head,
	output logic          empty,
	output logic          full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	upd_pkg::job_t  entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/upd_back.sv -----
// Back end: expands queued jobs into output words, one byte per cycle while out_stall is low.
module upd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  upd_pkg::job_t head,
	input  logic          empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_char,
	output logic          run_last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       run_last_q;
	logic       load;
	logic       last;
	logic [7:0] sel_char;

	assign load = !out_valid_q || !out_stall;
	assign last = (head.kind == upd_pkg::JOB_SINGLE) || (idx_q == upd_pkg::IDX_LAST);
	assign pop  = load && !empty && last;

	always_comb begin
		case (idx_q)
			upd_pkg::IDX_FIRST:
				sel_char = (head.kind == upd_pkg::JOB_SINGLE) ? head.ch_a : upd_pkg::CHAR_BTICK;
			upd_pkg::IDX_C1: sel_char = head.ch_a;
			upd_pkg::IDX_C2: sel_char = head.ch_b;
			default:         sel_char = upd_pkg::CHAR_APOS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= upd_pkg::IDX_FIRST;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty) begin
				idx_q <= last ? upd_pkg::IDX_FIRST : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			out_char_q <= sel_char;
			run_last_q <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign run_last  = run_last_q;

endmodule

// ----- rtl/url_percent_decoder_core.sv -----
// Top level of the URL percent decoder.
// Input channel: in_valid/in_stall carry one encoded byte (in_char) per word,
// with text_end set on the last byte of a text; escape state clears after it.
// Output channel: out_valid/out_stall carry one decoded byte (out_char) per
// word; run_last marks the last byte produced by a given input byte.
// The front end classifies each byte into a job (one byte, or a backtick form
// of four bytes for an unlisted escape) and pushes it into a QUEUE_DEPTH-entry
// job queue; bytes that produce nothing never enter the queue.
// An accepted input byte reaches the output through its queue entry and then the
// output register, given an empty queue and no stall.
// Throughput: one input byte per cycle while the queue has room; the back end
// emits one output byte per cycle while out_stall is low; a four-byte escape
// holds its entry until its last byte. The back end's byte counter sets the rate.
// in_stall is high exactly when the queue is full.
// Reset clears escape state, the queue and the output register; no clearing
// pass is needed. While out_stall is high the output word is held and the
// queue keeps filling until full.
module url_percent_decoder_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       text_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       run_last
);

	upd_pkg::job_t       push_job, head;
	upd_pkg::fe_status_t fe_status;
	logic                push, pop, q_empty, q_full;

	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_char  (in_char),
		.text_end (text_end),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job),
		.status   (fe_status)
	);

	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	upd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.run_last  (run_last)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("job popped from empty queue");

	a_text_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && text_end |=> fe_status.idle)
		else $error("escape state survived end of text");

	a_back_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty && !out_valid |=> out_valid)
		else $error("queued job not emitted while output free");

endmodule

// ----- sim/url_percent_decoder_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for url_percent_decoder_core: directed table, random texts, scoreboard.
module url_percent_decoder_core_tb;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 11;
	localparam int PHASE_WORDS  = 101;
	localparam int HOLD_CYCLES  = 60;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [2:0] {
		ESC_IDLE = 3'b001,
		ESC_OPEN = 3'b010,
		ESC_HALF = 3'b100
	} esc_phase_t;

	// One input word; where fixed is set the decoded bytes are typed in, first byte in [31:24].
	typedef struct packed {
		logic [7:0]  ch;
		logic        last;
		logic        fixed;
		logic [2:0]  n_typed;
		logic [31:0] typed_bytes;
	} text_word_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} decoded_word_t;

	localparam text_word_t DIRECTED [25] = '{
		'{"A",       1'b0, 1'b1, 3'd1, {"A", 24'h0}},
		'{8'h00,     1'b0, 1'b1, 3'd0, 32'h0},
		'{8'hFF,     1'b0, 1'b1, 3'd0, 32'h0},
		'{upd_pkg::CHAR_PLUS, 1'b0, 1'b1, 3'd1, {upd_pkg::CHAR_SP, 24'h0}},
		'{upd_pkg::CHAR_PCT,  1'b0, 1'b0, 3'd0, 32'h0},
		'{"2",       1'b0, 1'b0, 3'd0, 32'h0},
		'{"1",       1'b0, 1'b0, 3'd0, 32'h0},
		'{upd_pkg::CHAR_PCT,  1'b0, 1'b0, 3'd0, 32'h0},
		'{"0",       1'b0, 1'b0, 3'd0, 32'h0},
		'{"D",       1'b0, 1'b1, 3'd1, {upd_pkg::CHAR_NL, 24'h0}},
		'{upd_pkg::CHAR_PCT,  1'b0, 1'b0, 3'd0, 32'h0},
		'{"0",       1'b0, 1'b0, 3'd0, 32'h0},
		'{"a",       1'b0, 1'b1, 3'd0, 32'h0},
		'{upd_pkg::CHAR_PCT,  1'b0, 1'b0, 3'd0, 32'h0},
		'{8'h80,     1'b0, 1'b0, 3'd0, 32'h0},
		'{8'hFF,     1'b0, 1'b1, 3'd4,
			{upd_pkg::CHAR_BTICK, 8'h80, 8'hFF, upd_pkg::CHAR_APOS}},
		'{upd_pkg::CHAR_PCT,  1'b0, 1'b0, 3'd0, 32'h0},
		'{"7",       1'b0, 1'b0, 3'd0, 32'h0},
		'{"e",       1'b0, 1'b0, 3'd0, 32'h0},
		'{upd_pkg::CHAR_PCT,  1'b0, 1'b0, 3'd0, 32'h0},
		'{"4",       1'b1, 1'b0, 3'd0, 32'h0},
		'{upd_pkg::CHAR_PCT,  1'b1, 1'b0, 3'd0, 32'h0},
		'{"z",       1'b0, 1'b0, 3'd0, 32'h0},
		'{"_",       1'b0, 1'b0, 3'd0, 32'h0},
		'{"~",       1'b0, 1'b1, 3'd0, 32'h0}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_char;
	logic       text_end;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_char;
	logic       run_last;

	url_percent_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_char   (in_char),
		.text_end  (text_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.run_last  (run_last)
	);

	always #HALF_PERIOD clk = ~clk;

	esc_phase_t    esc_phase = ESC_IDLE;
	logic [7:0]    esc_first = 8'h00;
	decoded_word_t decoded_q[$];
	text_word_t    text_q[$];
	text_word_t    drive_word;
	int            send_idle_pct = 0;
	int            stall_pct = 0;
	bit            hold_req = 1'b0;
	int            mismatches = 0;
	int            quiet_cycles = 0;

	// Bit 8 set when the pair is on the whitelist; bits 7:0 the decoded byte.
	function automatic logic [8:0] listed_escape(logic [7:0] c1, logic [7:0] c2);
		logic [4:0] lo;
		logic       ok;
		lo = 5'd16;
		if (c2 >= "0" && c2 <= "9") lo = 5'(c2 - "0");
		else if (c2 >= "A" && c2 <= "F") lo = 5'(c2 - "A" + 8'd10);
		else if (c2 >= "a" && c2 <= "f") lo = 5'(c2 - "a" + 8'd10);
		if (lo > 5'd15) return 9'h0;
		case (c1)
			"2": ok = (lo >= 5'd1);
			"3": ok = (lo >= 5'd10);
			"4": ok = (c2 == "0");
			"5": ok = (lo >= 5'd11);
			"6": ok = (c2 == "0");
			"7": ok = (lo >= 5'd11 && lo <= 5'd14);
			default: ok = 1'b0;
		endcase
		return ok ? {1'b1, c1[3:0], lo[3:0]} : 9'h0;
	endfunction

	// Advances the escape state by one input byte and returns the bytes it yields.
	function automatic void decode_byte(input logic [7:0] c, input logic last,
			output logic [3:0][7:0] bytes, output int n);
		logic [7:0] c1;
		logic [8:0] pv;
		n = 0;
		bytes = '0;
		unique case (esc_phase)
			ESC_OPEN: begin
				esc_first = c;
				esc_phase = ESC_HALF;
			end
			ESC_HALF: begin
				c1 = esc_first;
				esc_phase = ESC_IDLE;
				esc_first = 8'h00;
				if (c1 == "0" && (c == "D" || c == "d")) begin
					bytes[0] = upd_pkg::CHAR_NL;
					n = 1;
				end else if (!(c1 == "0" && (c == "A" || c == "a"))) begin
					pv = listed_escape(c1, c);
					if (pv[8]) begin
						bytes[0] = pv[7:0];
						n = 1;
					end else begin
						bytes[0] = upd_pkg::CHAR_BTICK;
						bytes[1] = c1;
						bytes[2] = c;
						bytes[3] = upd_pkg::CHAR_APOS;
						n = 4;
					end
				end
			end
			default: begin
				esc_phase = ESC_IDLE;
				if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
						(c >= "0" && c <= "9") ||
						c == upd_pkg::CHAR_SP || c == upd_pkg::CHAR_NL ||
						c == "&" || c == "." || c == "=" || c == "_") begin
					bytes[0] = c;
					n = 1;
				end else if (c == upd_pkg::CHAR_PLUS) begin
					bytes[0] = upd_pkg::CHAR_SP;
					n = 1;
				end else if (c == upd_pkg::CHAR_PCT) begin
					esc_phase = ESC_OPEN;
				end
			end
		endcase
		if (last) begin
			esc_phase = ESC_IDLE;
			esc_first = 8'h00;
		end
	endfunction

	function automatic text_word_t plain_word(logic [7:0] c, logic last);
		return '{c, last, 1'b0, 3'd0, 32'h0};
	endfunction

	function automatic logic [7:0] hex_digit(int unsigned v);
		if (v < 10) return "0" + 8'(v);
		return (($urandom_range(1) != 0) ? "a" : "A") + 8'(v) - 8'd10;
	endfunction

	function automatic logic [7:0] pass_char();
		case ($urandom_range(3))
			0: return "A" + 8'($urandom_range(25));
			1: return "a" + 8'($urandom_range(25));
			2: return "0" + 8'($urandom_range(9));
			default: begin
				case ($urandom_range(5))
					0: return upd_pkg::CHAR_SP;
					1: return upd_pkg::CHAR_NL;
					2: return "&";
					3: return ".";
					4: return "=";
					default: return "_";
				endcase
			end
		endcase
	endfunction

	// Mostly well-formed escapes and pass-set bytes, with noise and cut-off escapes.
	function automatic void queue_random_chunk();
		int unsigned pick;
		int unsigned r;
		logic [7:0]  c1;
		logic [7:0]  c2;
		logic        end_here;
		pick = $urandom_range(99);
		end_here = ($urandom_range(19) == 0);
		if (pick < 40) begin
			text_q.push_back(plain_word(pass_char(), end_here));
		end else if (pick < 50) begin
			text_q.push_back(plain_word(8'($urandom_range(255)), end_here));
		end else if (pick < 55) begin
			text_q.push_back(plain_word(upd_pkg::CHAR_PLUS, end_here));
		end else begin
			r = $urandom_range(99);
			if (r < 70) begin
				r = $urandom_range(6);
				c1 = (r == 0) ? "0" : "0" + 8'(r + 1);
			end else if (r < 85) begin
				c1 = hex_digit($urandom_range(15));
			end else begin
				c1 = 8'($urandom_range(255));
			end
			r = $urandom_range(99);
			if (r < 60) c2 = hex_digit($urandom_range(15));
			else if (r < 80) c2 = ($urandom_range(1) != 0) ? hex_digit(13) : hex_digit(10);
			else c2 = 8'($urandom_range(255));
			if (pick < 90) begin
				text_q.push_back(plain_word(upd_pkg::CHAR_PCT, 1'b0));
				text_q.push_back(plain_word(c1, 1'b0));
				text_q.push_back(plain_word(c2, end_here));
			end else if (pick < 95) begin
				text_q.push_back(plain_word(upd_pkg::CHAR_PCT, 1'b0));
				text_q.push_back(plain_word(c1, 1'b1));
			end else begin
				text_q.push_back(plain_word(upd_pkg::CHAR_PCT, 1'b1));
			end
		end
	endfunction

	// Called and returns at a falling edge; valid stays high into the next word when no gap.
	task automatic send_word(input text_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_char <= w.ch;
		text_end <= w.last;
		drive_word = w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Scoreboard: predicted bytes go in on input acceptance, checked on output acceptance.
	always @(posedge clk) begin : scoreboard
		logic [3:0][7:0] pred;
		int              n;
		decoded_word_t   want;
		logic [7:0]      b;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (in_valid && !in_stall) begin
				decode_byte(drive_word.ch, drive_word.last, pred, n);
				if (drive_word.fixed) n = int'(drive_word.n_typed);
				for (int i = 0; i < n; i++) begin
					b = drive_word.fixed ? drive_word.typed_bytes[31 - 8 * i -: 8] : pred[i];
					decoded_q.push_back('{b, (i == n - 1)});
				end
			end
			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual out_char %h run_last %b",
						$time, out_char, run_last);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					if (out_char !== want.ch) begin
						$display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
						mismatches++;
					end
					if (run_last !== want.last) begin
						$display("%0t: run_last expected %b actual %b", $time, want.last, run_last);
						mismatches++;
					end
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off to fill the block's queue.
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		wait (arst_n);
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_char = 8'h00;
		text_end = 1'b0;
		out_stall = 1'b0;
		drive_word = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i]) send_word(DIRECTED[i]);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
					hold_req = 1'b1;
				end
				1: begin
					send_idle_pct = 81;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 81;
				end
				default: begin
					send_idle_pct = 17;
					stall_pct = 17;
				end
			endcase
			text_q.delete();
			while (text_q.size() < PHASE_WORDS) queue_random_chunk();
			foreach (text_q[i]) send_word(text_q[i]);
		end
		in_valid <= 1'b0;

		while (decoded_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder_core.sv
sim/url_percent_decoder_core_tb.sv
